// ===== sv/trce_pkg.sv =====
// Shared types, constants and character functions of the timestamp root code encoder.
package trce_pkg;

  // Configuration register map (word index = paddr[2])
  localparam int          CFG_AW        = 3;
  localparam logic        REG_BREAK_IDX = 1'b0;
  localparam logic [31:0] BREAK_RESET   = 32'd1519659904;

  // Code step in seconds
  localparam logic [2:0] STEP_NEW = 3'd1;
  localparam logic [2:0] STEP_OLD = 3'd4;

  // Year reduction: year / 100 via reciprocal 655 / 2^16, then one correction
  localparam logic [9:0] YEAR_RECIP = 10'd655;
  localparam logic [6:0] YEAR_MOD   = 7'd100;
  localparam logic [6:0] YEAR_EPOCH = 7'd79;
  localparam logic [6:0] YEAR_WRAP  = 7'd21;   // 100 - 79
  localparam logic [8:0] LEAP_DAY   = 9'd366;
  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;

  // 4-second periods per year, day, hour, minute
  localparam logic [22:0] YEAR_TICKS = 23'd7884000;
  localparam logic [14:0] DAY_TICKS  = 15'd21600;
  localparam logic [9:0]  HOUR_TICKS = 10'd900;
  localparam logic [3:0]  MIN_TICKS  = 4'd15;

  // Digit extraction: base 36 = 4 * 9, base 26 = 2 * 13.
  // Reciprocals floor(2^32 / 9) and floor(2^32 / 13) leave at most one short.
  localparam logic [28:0] RECIP_9   = 29'd477218588;
  localparam logic [28:0] RECIP_13  = 29'd330382099;
  localparam logic [3:0]  ODD_36    = 4'd9;
  localparam logic [3:0]  ODD_26    = 4'd13;
  localparam int          NUM_DIGITS = 5;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_UPPER = 8'd55;   // 'A' - 10
  localparam logic [7:0] ASCII_LOWER = 8'd97;
  localparam logic [7:0] DEC_LIMIT   = 8'd10;

  typedef struct packed {
    logic        code_ok;
    logic        new_fmt;
    logic [2:0]  step;
    logic [32:0] value;     // offset (base 36) or period count (base 26)
  } trce_job_t;

  typedef struct packed {
    trce_job_t      job;
    logic [4:0][7:0] chars; // [0] least significant digit; each new digit enters at [4]
  } trce_work_t;

  function automatic logic [7:0] b36_char(input logic [7:0] m);
    logic [7:0] c;
    if (m < DEC_LIMIT) begin
      c = ASCII_ZERO + m;
    end else begin
      c = ASCII_UPPER + m;
    end
    return c;
  endfunction

  function automatic logic [7:0] alpha_char(input logic [7:0] m);
    return ASCII_LOWER + m;
  endfunction

endpackage

// ===== sv/timestamp_root_code_encoder_top.sv =====
// Top level of the timestamp root code encoder: register port, front, queue and back.
// Throughput: one request per cycle while out_stall is low, set by the fully pipelined
// front (4 stages) and the ten-stage digit chain (5 digits, reciprocal multiply then
// correction for each).
// Reset (rst_n low, synchronous): empties all stages and the queue, and loads
// break_time with 1519659904.
module timestamp_root_code_encoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_unix_seconds,
  input  logic [13:0]                 in_year_value,
  input  logic [8:0]                  in_day_of_year,
  input  logic [4:0]                  in_hour_value,
  input  logic [5:0]                  in_minute_value,
  input  logic signed [15:0]          in_second_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_code_valid,
  output logic                        out_new_format,
  output logic [2:0]                  out_step_seconds,
  output logic [7:0]                  out_char_0,
  output logic [7:0]                  out_char_1,
  output logic [7:0]                  out_char_2,
  output logic [7:0]                  out_char_3,
  output logic [7:0]                  out_char_4,
  output logic [7:0]                  out_char_5,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trce_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import trce_pkg::*;

  // break_time register; the user must write it only while the block is idle, the block does not enforce this
  logic [31:0] break_r;
  logic        sel_break;

  logic        fq_valid, fq_stall;
  trce_job_t   fq_job;
  logic        qb_valid, qb_stall;
  trce_job_t   qb_job;
  logic [5:0][7:0] chars;

  assign pready    = 1'b1;
  assign sel_break = paddr[2] == REG_BREAK_IDX;
  assign prdata    = sel_break ? break_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_r <= BREAK_RESET;
    end else if (psel && penable && pwrite && sel_break) begin
      break_r <= pwdata;
    end
  end

  // Front: add seconds, compare with the break, check the date, build the count
  trce_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .break_time   (break_r),
    .up_valid     (in_valid),
    .up_stall     (in_stall),
    .unix_seconds (in_unix_seconds),
    .year_value   (in_year_value),
    .day_of_year  (in_day_of_year),
    .hour_value   (in_hour_value),
    .minute_value (in_minute_value),
    .second_value (in_second_value),
    .dn_valid     (fq_valid),
    .dn_stall     (fq_stall),
    .dn_job       (fq_job)
  );

  // Queue: lets the front keep taking requests while the back holds
  trce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fq_valid),
    .up_stall (fq_stall),
    .up_job   (fq_job),
    .dn_valid (qb_valid),
    .dn_stall (qb_stall),
    .dn_job   (qb_job)
  );

  // Back: peel off five digits, least significant first, then the leading one
  trce_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (qb_valid),
    .up_stall      (qb_stall),
    .up_job        (qb_job),
    .dn_valid      (out_valid),
    .dn_stall      (out_stall),
    .dn_code_valid (out_code_valid),
    .dn_new_format (out_new_format),
    .dn_step       (out_step_seconds),
    .dn_chars      (chars)
  );

  assign out_char_0 = chars[5];
  assign out_char_1 = chars[4];
  assign out_char_2 = chars[3];
  assign out_char_3 = chars[2];
  assign out_char_4 = chars[1];
  assign out_char_5 = chars[0];

endmodule

// ===== sv/trce_front.sv =====
// Front part: takes requests, forms the sum, picks the format, checks the date, builds the job.
module trce_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         break_time,
  input  logic                up_valid,
  output logic                up_stall,
  input  logic [31:0]         unix_seconds,
  input  logic [13:0]         year_value,
  input  logic [8:0]          day_of_year,
  input  logic [4:0]          hour_value,
  input  logic [5:0]          minute_value,
  input  logic signed [15:0]  second_value,
  output logic                dn_valid,
  input  logic                dn_stall,
  output trce_pkg::trce_job_t dn_job
);
  import trce_pkg::*;

  // stage 1
  logic        v1_r;
  logic [31:0] unix1_r;
  logic [33:0] sum1_r;
  logic [7:0]  yq1_r;
  logic [13:0] year1_r;
  logic [8:0]  day1_r;
  logic [4:0]  hour1_r;
  logic [5:0]  min1_r;
  logic [15:0] sec1_r;
  // stage 2
  logic        v2_r;
  logic        newf2_r;
  logic [2:0]  step2_r;
  logic [32:0] u2_r;
  logic [6:0]  y2_r;
  logic [8:0]  day2_r;
  logic [4:0]  hour2_r;
  logic [5:0]  min2_r;
  logic [12:0] sec42_r;
  logic        rng2_r;
  // stage 3
  logic        v3_r;
  logic        newf3_r;
  logic [2:0]  step3_r;
  logic [32:0] u3_r;
  logic        ok3_r;
  logic [29:0] a3_r;
  logic [24:0] b3_r;
  logic [15:0] c3_r;
  // stage 4
  logic        v4_r;
  trce_job_t   job4_r;

  logic go1, go2, go3, go4;

  logic [23:0] yprod_nxt;
  logic [33:0] sum_nxt;
  logic        newf_nxt;
  logic [33:0] diff_nxt;
  logic [13:0] yr_wide_nxt;
  logic [7:0]  yr0_nxt;
  logic [6:0]  ymod_nxt;
  logic [6:0]  y_nxt;
  logic        rng_nxt;
  logic [4:0]  leaps_nxt;
  logic [9:0]  dl_nxt;
  logic        ok_nxt;
  logic [29:0] elapsed_nxt;
  trce_job_t   job_nxt;

  assign go4 = !v4_r || !dn_stall;
  assign go3 = !v3_r || go4;
  assign go2 = !v2_r || go3;
  assign go1 = !v1_r || go2;
  assign up_stall = !go1;

  assign dn_valid = v4_r;
  assign dn_job   = job4_r;

  // stage 1 inputs
  assign sum_nxt   = {2'b00, unix_seconds} + {{18{second_value[15]}}, second_value};
  assign yprod_nxt = 24'(year_value) * 24'(YEAR_RECIP);

  // stage 2 inputs
  assign newf_nxt    = $signed(sum1_r) >= $signed({2'b00, break_time});
  assign diff_nxt    = sum1_r - {2'b00, break_time};
  assign yr_wide_nxt = year1_r - 14'(yq1_r) * 14'(YEAR_MOD);
  assign yr0_nxt     = yr_wide_nxt[7:0];
  assign ymod_nxt    = (yr0_nxt >= 8'(YEAR_MOD)) ? 7'(yr0_nxt - 8'(YEAR_MOD)) : yr0_nxt[6:0];
  assign y_nxt       = (ymod_nxt >= YEAR_EPOCH) ? (ymod_nxt - YEAR_EPOCH)
                                                : (ymod_nxt + YEAR_WRAP);
  assign rng_nxt     = (day1_r != 9'd0) && (day1_r <= LEAP_DAY) && (hour1_r <= MAX_HOUR) &&
                       (min1_r <= MAX_MINUTE) && !sec1_r[15];

  // stage 3 inputs: day 366 only in a leap year, i.e. y mod 4 == 1
  assign leaps_nxt = 5'((y2_r + 7'd2) >> 2);
  assign dl_nxt    = 10'(day2_r) + 10'(leaps_nxt) - 10'd1;
  assign ok_nxt    = rng2_r && !((day2_r == LEAP_DAY) && (y2_r[1:0] != 2'b01));

  // stage 4 inputs
  assign elapsed_nxt = a3_r + 30'(b3_r) + 30'(c3_r);

  always_comb begin
    job_nxt.new_fmt = newf3_r;
    job_nxt.step    = step3_r;
    job_nxt.code_ok = newf3_r || ok3_r;
    if (newf3_r) begin
      job_nxt.value = u3_r;
    end else if (ok3_r) begin
      job_nxt.value = 33'(elapsed_nxt);
    end else begin
      job_nxt.value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (go1) v1_r <= up_valid;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      unix1_r <= unix_seconds;
      sum1_r  <= sum_nxt;
      yq1_r   <= yprod_nxt[23:16];
      year1_r <= year_value;
      day1_r  <= day_of_year;
      hour1_r <= hour_value;
      min1_r  <= minute_value;
      sec1_r  <= second_value;
    end
    if (go2) begin
      newf2_r <= newf_nxt;
      step2_r <= (unix1_r >= break_time) ? STEP_NEW : STEP_OLD;
      u2_r    <= diff_nxt[32:0];
      y2_r    <= y_nxt;
      day2_r  <= day1_r;
      hour2_r <= hour1_r;
      min2_r  <= min1_r;
      sec42_r <= sec1_r[14:2];
      rng2_r  <= rng_nxt;
    end
    if (go3) begin
      newf3_r <= newf2_r;
      step3_r <= step2_r;
      u3_r    <= u2_r;
      ok3_r   <= ok_nxt;
      a3_r    <= 30'(y2_r) * 30'(YEAR_TICKS);
      b3_r    <= 25'(dl_nxt) * 25'(DAY_TICKS);
      c3_r    <= 16'(hour2_r) * 16'(HOUR_TICKS) + 16'(min2_r) * 16'(MIN_TICKS) +
                 16'(sec42_r);
    end
    if (go4) begin
      job4_r <= job_nxt;
    end
  end

endmodule

// ===== sv/trce_queue.sv =====
// Short queue of jobs between the front and the back part.
module trce_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  trce_pkg::trce_job_t up_job,
  output logic                dn_valid,
  input  logic                dn_stall,
  output trce_pkg::trce_job_t dn_job
);
  import trce_pkg::*;

  trce_job_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           full;
  logic           push;
  logic           pop;

  assign full     = cnt_r == (QAW+1)'(QDEPTH);
  assign up_stall = full;
  assign dn_valid = cnt_r != '0;
  assign dn_job   = mem_r[rd_ptr_r];
  assign push     = up_valid && !full;
  assign pop      = dn_valid && !dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= up_job;
  end

endmodule

// ===== sv/trce_digit.sv =====
// One digit step: divide by 36 or 26 through a reciprocal multiply, then correct.
module trce_digit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  trce_pkg::trce_work_t up_work,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output trce_pkg::trce_work_t dn_work
);
  import trce_pkg::*;

  logic        va_r;
  trce_work_t  wa_r;
  logic [27:0] qa_r;
  logic        vb_r;
  trce_work_t  wb_r;

  logic        goa, gob;
  logic [30:0] xin;
  logic [59:0] prod;
  logic [30:0] xa;
  logic [3:0]  odd;
  logic [30:0] rem_wide;
  logic [4:0]  r0;
  logic [3:0]  r;
  logic [27:0] q;
  logic [7:0]  rem36;
  logic [7:0]  rem26;
  logic [7:0]  ch;
  trce_work_t  wb_nxt;

  assign gob      = !vb_r || !dn_stall;
  assign goa      = !va_r || gob;
  assign up_stall = !goa;
  assign dn_valid = vb_r;
  assign dn_work  = wb_r;

  // first half: estimate the quotient by the odd factor
  assign xin  = up_work.job.new_fmt ? up_work.job.value[32:2] : up_work.job.value[31:1];
  assign prod = 60'(xin) * 60'(up_work.job.new_fmt ? RECIP_9 : RECIP_13);

  // second half: the estimate is exact or one short
  assign xa       = wa_r.job.new_fmt ? wa_r.job.value[32:2] : wa_r.job.value[31:1];
  assign odd      = wa_r.job.new_fmt ? ODD_36 : ODD_26;
  assign rem_wide = xa - 31'(qa_r) * 31'(odd);
  assign r0       = rem_wide[4:0];

  always_comb begin
    if (r0 >= 5'(odd)) begin
      q = qa_r + 28'd1;
      r = 4'(r0 - 5'(odd));
    end else begin
      q = qa_r;
      r = r0[3:0];
    end
  end

  assign rem36 = {2'b00, r, wa_r.job.value[1:0]};
  assign rem26 = {3'b000, r, wa_r.job.value[0]};
  assign ch    = wa_r.job.new_fmt ? b36_char(rem36) : alpha_char(rem26);

  always_comb begin
    wb_nxt           = wa_r;
    wb_nxt.job.value = 33'(q);
    wb_nxt.chars     = {ch, wa_r.chars[4:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (goa) va_r <= up_valid;
      if (gob) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (goa) begin
      wa_r <= up_work;
      qa_r <= prod[59:32];
    end
    if (gob) begin
      wb_r <= wb_nxt;
    end
  end

endmodule

// ===== sv/trce_back.sv =====
// Back part: chain of digit steps, leading digit and the result register.
module trce_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  trce_pkg::trce_job_t up_job,
  output logic                dn_valid,
  input  logic                dn_stall,
  output logic                dn_code_valid,
  output logic                dn_new_format,
  output logic [2:0]          dn_step,
  output logic [5:0][7:0]     dn_chars     // [5] is the leading character
);
  import trce_pkg::*;

  logic [NUM_DIGITS:0] dv;
  logic [NUM_DIGITS:0] ds;
  trce_work_t          dw [NUM_DIGITS+1];

  logic            out_v_r;
  logic            code_ok_r;
  logic            new_fmt_r;
  logic [2:0]      step_r;
  logic [5:0][7:0] chars_r;
  logic            go;
  trce_work_t      last;
  logic [7:0]      lead;

  assign dv[0]         = up_valid;
  assign dw[0].job     = up_job;
  assign dw[0].chars   = '0;
  assign up_stall      = ds[0];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
    trce_digit u_digit (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv[i]),
      .up_stall (ds[i]),
      .up_work  (dw[i]),
      .dn_valid (dv[i+1]),
      .dn_stall (ds[i+1]),
      .dn_work  (dw[i+1])
    );
  end

  assign go             = !out_v_r || !dn_stall;
  assign ds[NUM_DIGITS] = !go;
  assign last           = dw[NUM_DIGITS];

  // leading digit is not reduced and may run past the alphabet
  assign lead = last.job.new_fmt ? b36_char(last.job.value[7:0])
                                 : alpha_char(last.job.value[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= dv[NUM_DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      step_r    <= last.job.step;
      code_ok_r <= last.job.code_ok;
      new_fmt_r <= last.job.new_fmt && last.job.code_ok;
      if (last.job.code_ok) begin
        chars_r <= {lead, last.chars};
      end else begin
        chars_r <= '0;
      end
    end
  end

  assign dn_valid      = out_v_r;
  assign dn_code_valid = code_ok_r;
  assign dn_new_format = new_fmt_r;
  assign dn_step       = step_r;
  assign dn_chars      = chars_r;

endmodule

// ===== tb/tb_timestamp_root_code_encoder_top.sv =====
// Self-checking testbench for the timestamp root code encoder: directed and random stamps.
`timescale 1ns / 1ps

module tb_timestamp_root_code_encoder_top;
  import trce_pkg::*;

  // Ticks (4-second periods) per year, day, hour and minute of the old format
  localparam longint YEAR_PERIODS = 7884000;
  localparam longint DAY_PERIODS  = 21600;
  localparam longint HOUR_PERIODS = 900;
  localparam longint MIN_PERIODS  = 15;
  // Weight of the leading character in each format
  localparam longint B36_LEAD = 60466176;   // 36^5
  localparam longint B26_LEAD = 11881376;   // 26^5

  localparam logic [CFG_AW-1:0] BREAK_ADDR = {REG_BREAK_IDX, 2'b00};

  localparam int NUM_PHASES     = 6;
  localparam int RAND_PER_PHASE = 330;
  localparam int DRAIN_CYCLES   = 32;    // margin beyond the pipeline depth
  localparam int LONG_HOLD      = 400;   // receiver hold-off, cycles
  localparam int HOLD_AT_CODE   = 300;   // result count that triggers the hold-off

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [13:0] year_value;
    logic [8:0]  day_of_year;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [15:0] second_value;
  } stamp_req_t;

  typedef struct packed {
    logic            code_valid;
    logic            new_format;
    logic [2:0]      step_seconds;
    logic [5:0][7:0] chars;        // [0] is the most significant character
  } root_code_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Request channel
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [31:0] in_unix_seconds = '0;
  logic [13:0] in_year_value   = '0;
  logic [8:0]  in_day_of_year  = '0;
  logic [4:0]  in_hour_value   = '0;
  logic [5:0]  in_minute_value = '0;
  logic [15:0] in_second_value = '0;

  // Result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_code_valid;
  logic       out_new_format;
  logic [2:0] out_step_seconds;
  logic [7:0] out_char_0, out_char_1, out_char_2, out_char_3, out_char_4, out_char_5;

  // Register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  timestamp_root_code_encoder_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_unix_seconds  (in_unix_seconds),
    .in_year_value    (in_year_value),
    .in_day_of_year   (in_day_of_year),
    .in_hour_value    (in_hour_value),
    .in_minute_value  (in_minute_value),
    .in_second_value  (in_second_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_valid   (out_code_valid),
    .out_new_format   (out_new_format),
    .out_step_seconds (out_step_seconds),
    .out_char_0       (out_char_0),
    .out_char_1       (out_char_1),
    .out_char_2       (out_char_2),
    .out_char_3       (out_char_3),
    .out_char_4       (out_char_4),
    .out_char_5       (out_char_5),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Stamps waiting to be offered, and codes waiting to come out
  stamp_req_t stamp_pending[$];
  root_code_t codes_expected[$];

  logic [31:0] brk_model = BREAK_RESET;   // our copy of break_time
  int          failures  = 0;
  int          codes_seen = 0;
  int          hold_left  = 0;            // cycles left in the long hold-off
  bit          tx_free = 1'b0;            // sender offers back to back while set
  bit          rx_free = 1'b0;            // receiver takes no random stall while set
  bit          long_hold_done = 1'b0;

  // Compute the code the block must give for one stamp under break time brk.
  function automatic root_code_t encode_root_code(input stamp_req_t r, input logic [31:0] brk);
    root_code_t c;
    longint     sec, total, off, weight, digit, yr, leaps, ticks, day, hour, minute;
    c = '0;
    c.step_seconds = (r.unix_seconds >= brk) ? STEP_NEW : STEP_OLD;
    sec   = longint'($signed(r.second_value));
    total = longint'(r.unix_seconds) + sec;

    if (total >= longint'(brk)) begin
      // New format: offset from the break in base 36, leading digit unreduced
      off    = total - longint'(brk);
      weight = B36_LEAD;
      c.code_valid = 1'b1;
      c.new_format = 1'b1;
      for (int k = 0; k < 6; k++) begin
        digit = off / weight;
        off   = off - digit * weight;
        c.chars[k] = (digit < 10) ? 8'(48 + digit) : 8'(55 + digit);
        weight = weight / 36;
      end
      return c;
    end

    // Old format: check the UT date, then count 4-second periods since 1979
    yr = longint'(r.year_value);
    yr = yr % 100 - 79;
    if (yr < 0) yr = yr + 100;
    leaps  = (yr + 2) / 4;
    day    = longint'(r.day_of_year);
    hour   = longint'(r.hour_value);
    minute = longint'(r.minute_value);
    if (day < 1 || day > 366) return c;
    if (day == 366 && ((yr + 3) % 4) != 0) return c;
    if (hour > 23 || minute > 59 || sec < 0) return c;

    ticks = yr * YEAR_PERIODS + (day + leaps - 1) * DAY_PERIODS
          + hour * HOUR_PERIODS + minute * MIN_PERIODS + sec / 4;
    c.code_valid = 1'b1;
    weight = 1;
    for (int k = 5; k > 0; k--) begin
      c.chars[k] = 8'(97 + (ticks / weight) % 26);
      weight = weight * 26;
    end
    c.chars[0] = 8'(97 + ticks / B26_LEAD);
    return c;
  endfunction

  function automatic stamp_req_t mk_stamp(input logic [31:0] now, input int year, input int day,
                                          input int hour, input int minute, input int sec);
    stamp_req_t r;
    r.unix_seconds = now;
    r.year_value   = 14'(year);
    r.day_of_year  = 9'(day);
    r.hour_value   = 5'(hour);
    r.minute_value = 6'(minute);
    r.second_value = 16'(sec);
    return r;
  endfunction

  // Random stamp: mostly well-formed dates around or below the break, some noise.
  function automatic stamp_req_t draw_stamp(input logic [31:0] brk);
    stamp_req_t r;
    case ($urandom_range(0, 2))
      0: r.unix_seconds = $urandom();
      1: r.unix_seconds = 32'(brk + $urandom_range(0, 80000) - 40000);
      default: r.unix_seconds = (brk == 0) ? $urandom() : $urandom_range(0, brk - 1);
    endcase
    r.year_value   = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 9999))
                                                 : 14'($urandom_range(1979, 2078));
    r.day_of_year  = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(1, 366));
    r.hour_value   = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 23));
    r.minute_value = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 59));
    case ($urandom_range(0, 3))
      0, 1: r.second_value = 16'($urandom_range(0, 59));
      2: r.second_value = 16'($urandom_range(0, 32767));
      default: r.second_value = 16'($urandom());
    endcase
    return r;
  endfunction

  function automatic int field_diff(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      return 1;
    end
    return 0;
  endfunction

  // Write break_time, read it back, and move our copy along with it.
  // Call only while the block is idle.
  task automatic set_break(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BREAK_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // write taken at this edge; go straight into a read setup
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("break_time readback: expected %0d, actual %0d", value, prdata);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    brk_model = value;
  endtask

  // Wait until every stamp is taken and every code has come out, then let the pipe settle.
  task automatic drain_codes();
    while (stamp_pending.size() != 0 || in_valid || codes_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: offer pending stamps, hold a stalled request, idle a random gap before each one.
  always @(posedge clk) begin : tx_proc
    int         gap;
    logic       held;
    stamp_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      held = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        // request taken: predict its code now, under the break time in force
        codes_expected.push_back(encode_root_code({in_unix_seconds, in_year_value,
                                                   in_day_of_year, in_hour_value,
                                                   in_minute_value, in_second_value},
                                                  brk_model));
        if ($urandom_range(0, 49) == 0) tx_free = !tx_free;
        gap = tx_free ? 0 : $urandom_range(0, 11);
      end
      if (!held) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (stamp_pending.size() != 0) begin
          nxt = stamp_pending.pop_front();
          in_unix_seconds <= nxt.unix_seconds;
          in_year_value   <= nxt.year_value;
          in_day_of_year  <= nxt.day_of_year;
          in_hour_value   <= nxt.hour_value;
          in_minute_value <= nxt.minute_value;
          in_second_value <= nxt.second_value;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: once enough codes have come out, hold the receiver off for a long
  // stretch so the block fills and stalls its input while the sender keeps offering.
  always @(posedge clk) begin : hold_proc
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && codes_seen >= HOLD_AT_CODE) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD;
    end
  end

  // Monitor: check each taken code against the oldest prediction, then stall a random while.
  always @(posedge clk) begin : rx_proc
    int         wait_left;
    root_code_t exp;
    root_code_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
      wait_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.code_valid   = out_code_valid;
        got.new_format   = out_new_format;
        got.step_seconds = out_step_seconds;
        got.chars[0] = out_char_0;
        got.chars[1] = out_char_1;
        got.chars[2] = out_char_2;
        got.chars[3] = out_char_3;
        got.chars[4] = out_char_4;
        got.chars[5] = out_char_5;
        if (codes_expected.size() == 0) begin
          $error("code came out with no request outstanding");
          failures++;
        end else begin
          exp = codes_expected.pop_front();
          failures += field_diff("code_valid", longint'(exp.code_valid),
                                 longint'(got.code_valid));
          failures += field_diff("new_format", longint'(exp.new_format),
                                 longint'(got.new_format));
          failures += field_diff("step_seconds", longint'(exp.step_seconds),
                                 longint'(got.step_seconds));
          for (int k = 0; k < 6; k++)
            failures += field_diff($sformatf("char_%0d", k), longint'(exp.chars[k]),
                                   longint'(got.chars[k]));
        end
        codes_seen++;
        if ($urandom_range(0, 49) == 0) rx_free = !rx_free;
        wait_left = rx_free ? 0 : $urandom_range(0, 11);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_stall <= (wait_left > 0) || (hold_left > 0);
    end
  end

  // Stimulus: directed stamps under the reset break time, then random phases across settings.
  initial begin : stim_proc
    logic [31:0] brk_plan [NUM_PHASES];
    logic [31:0] b;
    brk_plan[0] = BREAK_RESET;          // left at its reset value
    brk_plan[1] = 32'd0;                // everything at or past the break
    brk_plan[2] = 32'hFFFF_FFFF;        // nearly everything before the break
    brk_plan[3] = $urandom();
    brk_plan[4] = 32'h8000_0000;
    brk_plan[5] = BREAK_RESET;          // written back explicitly

    b = BREAK_RESET;
    // epoch, leap day in a leap year and in a common year
    stamp_pending.push_back(mk_stamp(0, 1979, 1, 0, 0, 0));
    stamp_pending.push_back(mk_stamp(0, 1980, 366, 0, 0, 0));
    stamp_pending.push_back(mk_stamp(0, 1981, 366, 0, 0, 0));
    // day, hour, minute and second out of range, and the last in-range second
    stamp_pending.push_back(mk_stamp(0, 1979, 0, 0, 0, 0));
    stamp_pending.push_back(mk_stamp(0, 1979, 367, 0, 0, 0));
    stamp_pending.push_back(mk_stamp(0, 1979, 511, 31, 63, -32768));
    stamp_pending.push_back(mk_stamp(0, 1979, 100, 24, 0, 0));
    stamp_pending.push_back(mk_stamp(0, 1979, 100, 23, 60, 0));
    stamp_pending.push_back(mk_stamp(0, 1979, 100, 23, 59, 59));
    stamp_pending.push_back(mk_stamp(0, 1979, 1, 0, 0, -1));
    // top of the old range: leading letter runs past the alphabet
    stamp_pending.push_back(mk_stamp(0, 2078, 365, 23, 59, 32767));
    // year wrap around the century
    stamp_pending.push_back(mk_stamp(0, 9999, 200, 12, 30, 17));
    stamp_pending.push_back(mk_stamp(0, 0, 200, 12, 30, 17));
    stamp_pending.push_back(mk_stamp(0, 8192, 60, 1, 2, 3));
    // around the break: format follows the sum, step follows unix time alone
    stamp_pending.push_back(mk_stamp(b - 1, 2018, 57, 0, 0, 0));
    stamp_pending.push_back(mk_stamp(b, 2018, 57, 0, 0, 0));
    stamp_pending.push_back(mk_stamp(b, 2018, 57, 0, 0, -1));
    stamp_pending.push_back(mk_stamp(b - 1, 2018, 57, 0, 0, 1));
    stamp_pending.push_back(mk_stamp(b - 5, 2018, 57, 0, 0, 4));
    stamp_pending.push_back(mk_stamp(b + 35, 2018, 57, 0, 0, 0));
    stamp_pending.push_back(mk_stamp(b + 36, 2018, 57, 0, 0, 0));
    // far past the break: leading digit runs past 'Z'
    stamp_pending.push_back(mk_stamp(32'hFFFF_FFFF, 2106, 38, 6, 28, 32767));
    stamp_pending.push_back(mk_stamp(32'hFFFF_FFFF, 2106, 38, 6, 28, -32768));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_codes();
        set_break(brk_plan[ph]);
      end
      repeat (RAND_PER_PHASE) stamp_pending.push_back(draw_stamp(brk_model));
    end

    drain_codes();
    if (failures == 0 && codes_expected.size() == 0) begin
      $display("timestamp_root_code_encoder_top verification clean");
    end else begin
      $display("timestamp_root_code_encoder_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("timestamp_root_code_encoder_top verification failed");
    $finish;
  end

endmodule
